// ===== rtl/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; the interfaces, datapath, controller and core use it.
package bpfa_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned IDX_W = 8;
	// pages held in one bitmap row of the memory
	localparam int unsigned ROW_BITS = 8;
	localparam int unsigned ROW_LOG = 3;

	localparam int unsigned POOL_PAGES_DEF = 2048;
	localparam int unsigned PAGE_BYTES_DEF = 4096;

	localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] POOL_LIMIT_RST = 32'h0090_0000;

	localparam logic [IDX_W-1:0] REG_POOL_BASE = 8'd0;
	localparam logic [IDX_W-1:0] REG_POOL_LIMIT = 8'd1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ALLOC_FAIL = 2'd1,
		ST_FREE_REJECT = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic scan_start;
		logic rd;
		logic scan_eval;
		logic fchk;
		logic rng_restart;
		logic row_inc;
		logic wr;
		logic fin;
		status_t code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_last;
		logic n_bad;
		logic found;
		logic free_bad;
		logic chk_bad;
		logic rng_last;
		logic slot_free;
	} sts_t;

endpackage

// ===== rtl/bpfa_if.sv =====
// Channel interfaces of the allocator: request, response and register write.
// Depends on bpfa_pkg for field widths and types.
interface bpfa_req_if;
	logic valid;
	logic ready;
	logic mode;
	logic [bpfa_pkg::CNT_W-1:0] page_count;
	logic [bpfa_pkg::ADDR_W-1:0] base_address;
	modport source (output valid, mode, page_count, base_address, input ready);
	modport sink (input valid, mode, page_count, base_address, output ready);
endinterface

interface bpfa_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [bpfa_pkg::ADDR_W-1:0] granted_address;
	logic [bpfa_pkg::CNT_W-1:0] pages_in_use;
	logic [bpfa_pkg::CNT_W-1:0] pages_available;
	modport source (output valid, status, granted_address, pages_in_use, pages_available,
		input ready);
	modport sink (input valid, status, granted_address, pages_in_use, pages_available,
		output ready);
endinterface

interface bpfa_cfg_if;
	logic valid;
	logic ready;
	logic [bpfa_pkg::IDX_W-1:0] index;
	logic [bpfa_pkg::ADDR_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bpfa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bpfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/bpfa_datapath.sv =====
// Datapath: registers, bitmap memory, run search, range masks and result register.
// Depends on bpfa_pkg, bpfa_ram and the channel interfaces.
module bpfa_datapath #(
	parameter int unsigned POOL_PAGES = bpfa_pkg::POOL_PAGES_DEF,
	parameter int unsigned PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bpfa_pkg::cmd_t   cmd,
	output bpfa_pkg::sts_t   sts,
	bpfa_req_if.sink         req,
	bpfa_rsp_if.source       rsp,
	bpfa_cfg_if.sink         cfg
);

	localparam int unsigned ROWS = POOL_PAGES / bpfa_pkg::ROW_BITS;
	localparam int unsigned ROW_W = $clog2(ROWS);
	localparam int unsigned PG_LOG = $clog2(PAGE_BYTES);
	localparam int unsigned CW = bpfa_pkg::CNT_W;
	localparam int unsigned AW = bpfa_pkg::ADDR_W;
	localparam int unsigned RB = bpfa_pkg::ROW_BITS;
	localparam int unsigned RL = bpfa_pkg::ROW_LOG;
	localparam logic [CW-1:0] POOL_CNT = CW'(POOL_PAGES);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

	logic [AW-1:0] base_q, limit_q;
	logic mode_q;
	logic [CW-1:0] n_q, run_q, first_q, last_q, used_q;
	logic [AW-1:0] addr_q;
	logic [ROW_W-1:0] row_q;
	logic [RB-1:0] rd_data, wr_data, mask;
	logic ram_wr;

	logic rsp_valid_q;
	bpfa_pkg::status_t rsp_status_q;
	logic [AW-1:0] rsp_addr_q;

	// register writes, always accepted
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bpfa_pkg::POOL_BASE_RST;
			limit_q <= bpfa_pkg::POOL_LIMIT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == bpfa_pkg::REG_POOL_BASE) begin
				base_q <= cfg.data;
			end else if (cfg.index == bpfa_pkg::REG_POOL_LIMIT) begin
				limit_q <= cfg.data;
			end
		end
	end

	// first-fit run search over one row
	logic found_c;
	logic [CW-1:0] run_c, fidx_c, afirst_c;
	always_comb begin
		run_c = run_q;
		found_c = 1'b0;
		fidx_c = '0;
		for (int b = 0; b < RB; b++) begin
			if (!found_c) begin
				if (!rd_data[b]) begin
					run_c = run_c + 1'b1;
					if (run_c == n_q) begin
						found_c = 1'b1;
						fidx_c = CW'({row_q, RL'(b)});
					end
				end else begin
					run_c = '0;
				end
			end
		end
		afirst_c = fidx_c + 1'b1 - n_q;
	end

	// free request checks on the held request
	logic [AW-1:0] off_c;
	logic [AW:0] span_c, need_c, fend_c;
	logic bad_c;
	always_comb begin
		off_c = (addr_q - base_q) >> PG_LOG;
		span_c = {1'b0, limit_q} - {1'b0, addr_q};
		need_c = (AW+1)'(n_q) << PG_LOG;
		fend_c = {1'b0, off_c} + (AW+1)'(n_q);
		bad_c = (addr_q == '0) || (addr_q[PG_LOG-1:0] != '0) || (addr_q < base_q) ||
			(n_q == '0) || (addr_q > limit_q) || (span_c < need_c) ||
			(fend_c > (AW+1)'(POOL_PAGES));
	end

	// pages of the current row inside the range
	always_comb begin
		for (int b = 0; b < RB; b++) begin
			mask[b] = (CW'({row_q, RL'(b)}) >= first_q) &&
				(CW'({row_q, RL'(b)}) <= last_q);
		end
	end

	// request and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else begin
			priority if (cmd.clr || cmd.row_inc) begin
				row_q <= row_q + 1'b1;
			end else if (cmd.scan_start) begin
				row_q <= '0;
			end else if (cmd.scan_eval) begin
				row_q <= found_c ? afirst_c[ROW_W+RL-1:RL] : row_q + 1'b1;
			end else if (cmd.fchk) begin
				row_q <= off_c[ROW_W+RL-1:RL];
			end else if (cmd.rng_restart) begin
				row_q <= first_q[ROW_W+RL-1:RL];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			n_q <= req.page_count;
			addr_q <= req.base_address;
		end
		if (cmd.scan_start) begin
			run_q <= '0;
		end else if (cmd.scan_eval) begin
			run_q <= run_c;
		end
		if (cmd.scan_eval && found_c) begin
			first_q <= afirst_c;
			last_q <= fidx_c;
		end else if (cmd.fchk) begin
			first_q <= off_c[CW-1:0];
			last_q <= off_c[CW-1:0] + n_q - 1'b1;
		end
	end

	// bitmap memory: one row read or written per cycle
	assign ram_wr = cmd.clr || cmd.wr;
	always_comb begin
		if (cmd.clr) begin
			wr_data = '0;
		end else if (mode_q == bpfa_pkg::MODE_FREE) begin
			wr_data = rd_data & ~mask;
		end else begin
			wr_data = rd_data | mask;
		end
	end

	bpfa_ram #(.WIDTH(RB), .DEPTH(ROWS)) u_map (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (row_q),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (row_q),
		.rd_data (rd_data)
	);

	// used count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.fin) begin
				rsp_valid_q <= 1'b1;
				if (cmd.code == bpfa_pkg::ST_OK) begin
					used_q <= (mode_q == bpfa_pkg::MODE_FREE) ? used_q - n_q : used_q + n_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_status_q <= cmd.code;
			if (cmd.code == bpfa_pkg::ST_OK && mode_q == bpfa_pkg::MODE_ALLOC) begin
				rsp_addr_q <= base_q + (AW'(first_q) << PG_LOG);
			end else begin
				rsp_addr_q <= '0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.granted_address = rsp_addr_q;
	assign rsp.pages_in_use = used_q;
	assign rsp.pages_available = POOL_CNT - used_q;

	assign sts.row_last = (row_q == ROW_MAX);
	assign sts.n_bad = (n_q == '0) || (n_q > POOL_CNT);
	assign sts.found = found_c;
	assign sts.free_bad = bad_c;
	assign sts.chk_bad = |(mask & ~rd_data);
	assign sts.rng_last = (row_q == last_q[ROW_W+RL-1:RL]);
	assign sts.slot_free = !rsp_valid_q || rsp.ready;

endmodule

// ===== rtl/bpfa_ctrl.sv =====
// Controller state machine: sequences clearing, scans, range checks and writes.
// Depends on bpfa_pkg.
module bpfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_mode,
	output logic           req_ready,
	input  bpfa_pkg::sts_t sts,
	output bpfa_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_ACHK  = 11'b000_0000_0100,
		S_AREAD = 11'b000_0000_1000,
		S_AEVAL = 11'b000_0001_0000,
		S_FCHK  = 11'b000_0010_0000,
		S_CREAD = 11'b000_0100_0000,
		S_CEVAL = 11'b000_1000_0000,
		S_WREAD = 11'b001_0000_0000,
		S_WWR   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	bpfa_pkg::status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q <= bpfa_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		res_d = res_q;
		cmd = '0;
		cmd.code = res_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.row_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = (req_mode == bpfa_pkg::MODE_FREE) ? S_FCHK : S_ACHK;
				end
			end
			S_ACHK: begin
				if (sts.n_bad) begin
					res_d = bpfa_pkg::ST_ALLOC_FAIL;
					state_d = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_AREAD;
				end
			end
			S_AREAD: begin
				cmd.rd = 1'b1;
				state_d = S_AEVAL;
			end
			S_AEVAL: begin
				cmd.scan_eval = 1'b1;
				if (sts.found) begin
					state_d = S_WREAD;
				end else if (sts.row_last) begin
					res_d = bpfa_pkg::ST_ALLOC_FAIL;
					state_d = S_DONE;
				end else begin
					state_d = S_AREAD;
				end
			end
			S_FCHK: begin
				cmd.fchk = 1'b1;
				if (sts.free_bad) begin
					res_d = bpfa_pkg::ST_FREE_REJECT;
					state_d = S_DONE;
				end else begin
					state_d = S_CREAD;
				end
			end
			S_CREAD: begin
				cmd.rd = 1'b1;
				state_d = S_CEVAL;
			end
			S_CEVAL: begin
				if (sts.chk_bad) begin
					res_d = bpfa_pkg::ST_FREE_REJECT;
					state_d = S_DONE;
				end else if (sts.rng_last) begin
					cmd.rng_restart = 1'b1;
					state_d = S_WREAD;
				end else begin
					cmd.row_inc = 1'b1;
					state_d = S_CREAD;
				end
			end
			S_WREAD: begin
				cmd.rd = 1'b1;
				state_d = S_WWR;
			end
			S_WWR: begin
				cmd.wr = 1'b1;
				if (sts.rng_last) begin
					res_d = bpfa_pkg::ST_OK;
					state_d = S_DONE;
				end else begin
					cmd.row_inc = 1'b1;
					state_d = S_WREAD;
				end
			end
			S_DONE: begin
				if (sts.slot_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/bitmap_page_frame_allocator_core.sv =====
// First-fit contiguous page allocator over a bitmap of POOL_PAGES used bits, stored
// eight pages to a memory row. After reset the block clears the bitmap, one row a cycle,
// and takes no request meanwhile (register writes are taken). An allocate request
// scans rows up to the end of the run found, then visits each row the run covers;
// a free request visits each row of the range to check it, then each row again to
// clear it. Each row visit is one read of the bitmap memory's port followed by the
// evaluate or write step. The result is held in an output register, so the next
// request can enter while it waits. PAGE_BYTES must be a power of two and POOL_PAGES
// a multiple of eight.
module bitmap_page_frame_allocator_core #(
	parameter int unsigned POOL_PAGES = bpfa_pkg::POOL_PAGES_DEF,
	parameter int unsigned PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bpfa_req_if.sink   req,
	bpfa_rsp_if.source rsp,
	bpfa_cfg_if.sink   cfg
);

	bpfa_pkg::cmd_t cmd;
	bpfa_pkg::sts_t sts;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpfa_datapath #(.POOL_PAGES(POOL_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule
